// File: src/mmpvf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmpvf_pkg
// Shared types and constants of the min/max partition victim filter.
// ----------------------------------------------------------------------------
package mmpvf_pkg;

   localparam int WAYS_DEFAULT        = 16;
   localparam int PARTITIONS_DEFAULT  = 16;
   localparam int COUNT_WIDTH_DEFAULT = 16;

   localparam int MAX_WAYS        = 16;
   localparam int MAX_PARTITIONS  = 16;
   localparam int PART_ID_WIDTH   = 4;
   localparam int LIMIT_WIDTH     = 16;
   localparam int CSR_INDEX_WIDTH = 1;

   typedef enum logic [2:0] {
      MODE_VICTIM = 3'd0,
      MODE_FILL   = 3'd1,
      MODE_EVICT  = 3'd2,
      MODE_WRITE  = 3'd3,
      MODE_READ   = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      KIND_MIN     = 2'd0,
      KIND_MAX     = 2'd1,
      KIND_SOFT    = 2'd2,
      KIND_UNKNOWN = 2'd3
   } kind_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_MAX_ENABLE = 1'b0,
      CSR_MIN_ENABLE = 1'b1
   } csr_index_type;

   typedef logic [2:0] pri_type;

   localparam pri_type PRI_NO_MAX    = 3'd0;
   localparam pri_type PRI_AT_MAX    = 3'd2;
   localparam pri_type PRI_UNDER_MAX = 3'd3;
   localparam pri_type PRI_BELOW_MIN = 3'd4;
   localparam pri_type PRI_NONE      = 3'd5;

   localparam logic [LIMIT_WIDTH-1:0] LIMIT_NONE = '1;

endpackage

// File: src/min_max_partition_victim_filter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_max_partition_victim_filter_core
// Per-partition occupancy and min/max limits with a two-stage victim filter.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one request per cycle unless stalled: victim choice, line
//   fill, line evict, limit write or limit read. rsp_* returns exactly one
//   response per request, in order. csr_* sets the max and min enables; the
//   user must do so only while idle, which the block does not enforce. A
//   response is taken on an edge with rsp_valid high and rsp_stall low.
// Flow:
//   a request is taken on an edge with req_valid high and req_stall low
//   into an input register; its response and any counter or limit update
//   then land together in the response register and the partition tables,
//   and each request sees the tables as left by the one before it.
// Stall:
//   while rsp_stall holds a waiting response, the request in the input
//   register waits too and req_stall goes high; nothing is dropped.
// Reset:
//   clears both enables and all occupancy counters, sets every min limit to
//   zero, every max limit to all ones and every soft flag to zero.
// ----------------------------------------------------------------------------
module min_max_partition_victim_filter_core #(
   parameter int WAYS        = mmpvf_pkg::WAYS_DEFAULT,
   parameter int PARTITIONS  = mmpvf_pkg::PARTITIONS_DEFAULT,
   parameter int COUNT_WIDTH = mmpvf_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,

   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic [2:0]                               req_mode,
   input  logic [mmpvf_pkg::PART_ID_WIDTH-1:0]      req_part_id,
   input  logic [63:0]                              req_way_partitions,
   input  logic [15:0]                              req_way_offered,
   input  logic [15:0]                              req_way_absent,
   input  logic [15:0]                              req_avail_bitmap,
   input  logic [1:0]                               req_limit_kind,
   input  logic [15:0]                              req_limit_value,

   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic [15:0]                              rsp_victim_mask,
   output logic [15:0]                              rsp_avail_mask,
   output logic [15:0]                              rsp_read_value,
   output logic                                     rsp_ok,

   input  logic                                     csr_write_enable,
   input  logic [mmpvf_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic                                     csr_write_data
);

   localparam int CMP_W = (COUNT_WIDTH > mmpvf_pkg::LIMIT_WIDTH) ?
                          COUNT_WIDTH : mmpvf_pkg::LIMIT_WIDTH;
   localparam logic [15:0] WAY_MASK = (WAYS >= mmpvf_pkg::MAX_WAYS) ? 16'hFFFF :
                                      16'((32'd1 << WAYS) - 32'd1);

   // candidates whose owner priority is the lowest among them
   function automatic logic [15:0] lowest_ways(input logic [15:0] cand,
                                               input logic [47:0] pri_vec);
      logic [7:0]                 seen;
      mmpvf_pkg::pri_type         minp;
      logic [15:0]                res;
      seen = '0;
      res  = '0;
      minp = mmpvf_pkg::PRI_NONE;
      for (int w = 0; w < 16; w++) begin
         if (cand[w]) begin
            seen[pri_vec[3*w +: 3]] = 1'b1;
         end
      end
      for (int l = 7; l >= 0; l--) begin
         if (seen[l]) begin
            minp = 3'(l);
         end
      end
      for (int w = 0; w < 16; w++) begin
         res[w] = cand[w] && (pri_vec[3*w +: 3] == minp);
      end
      return res;
   endfunction

   // configuration
   logic max_enable_ff, max_enable_in;
   logic min_enable_ff, min_enable_in;

   // partition tables
   logic [COUNT_WIDTH-1:0] occupancy_ff [PARTITIONS];
   logic [COUNT_WIDTH-1:0] occupancy_in [PARTITIONS];
   logic [15:0]            min_lines_ff [PARTITIONS];
   logic [15:0]            min_lines_in [PARTITIONS];
   logic [15:0]            max_lines_ff [PARTITIONS];
   logic [15:0]            max_lines_in [PARTITIONS];
   logic                   soft_flag_ff [PARTITIONS];
   logic                   soft_flag_in [PARTITIONS];

   // input register
   logic        s1_valid_ff, s1_valid_in;
   logic [2:0]  s1_mode_ff;
   logic [3:0]  s1_part_id_ff;
   logic [63:0] s1_way_partitions_ff;
   logic [15:0] s1_way_offered_ff;
   logic [15:0] s1_way_absent_ff;
   logic [15:0] s1_avail_bitmap_ff;
   logic [1:0]  s1_limit_kind_ff;
   logic [15:0] s1_limit_value_ff;

   // response register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_victim_mask_ff, rsp_victim_mask_in;
   logic [15:0] rsp_avail_mask_ff, rsp_avail_mask_in;
   logic [15:0] rsp_read_value_ff, rsp_read_value_in;
   logic        rsp_ok_ff, rsp_ok_in;

   logic advance;
   logic load;

   // effective per-id view, out-of-range ids read as reset values
   logic [CMP_W-1:0]   id_occ  [mmpvf_pkg::MAX_PARTITIONS];
   logic [15:0]        id_min  [mmpvf_pkg::MAX_PARTITIONS];
   logic [15:0]        id_max  [mmpvf_pkg::MAX_PARTITIONS];
   logic               id_soft [mmpvf_pkg::MAX_PARTITIONS];
   mmpvf_pkg::pri_type id_pri  [mmpvf_pkg::MAX_PARTITIONS];

   logic [47:0] way_pri;
   logic [15:0] own_ways;
   logic [15:0] offered;
   logic [15:0] after_max;
   logic [15:0] max_keep;
   logic [15:0] min_keep;
   logic [15:0] after_min;
   logic        over;
   logic        kind_known;
   logic [15:0] limit_read;

   assign advance   = s1_valid_ff && !(rsp_valid_ff && rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign load      = !req_stall;

   for (genvar i = 0; i < mmpvf_pkg::MAX_PARTITIONS; i++) begin : g_id
      if (i < PARTITIONS) begin : g_live
         assign id_occ[i]  = CMP_W'(occupancy_ff[i]);
         assign id_min[i]  = min_lines_ff[i];
         assign id_max[i]  = max_lines_ff[i];
         assign id_soft[i] = soft_flag_ff[i];
      end else begin : g_absent
         assign id_occ[i]  = '0;
         assign id_min[i]  = '0;
         assign id_max[i]  = mmpvf_pkg::LIMIT_NONE;
         assign id_soft[i] = 1'b0;
      end
      assign id_pri[i] = (id_occ[i] < CMP_W'(id_min[i])) ? mmpvf_pkg::PRI_BELOW_MIN :
                         !max_enable_ff                   ? mmpvf_pkg::PRI_NO_MAX    :
                         (id_occ[i] < CMP_W'(id_max[i])) ? mmpvf_pkg::PRI_UNDER_MAX :
                                                            mmpvf_pkg::PRI_AT_MAX;
   end

   for (genvar w = 0; w < mmpvf_pkg::MAX_WAYS; w++) begin : g_way
      assign way_pri[3*w +: 3] = id_pri[s1_way_partitions_ff[4*w +: 4]];
      assign own_ways[w]       = (s1_way_partitions_ff[4*w +: 4] == s1_part_id_ff);
      assign min_keep[w]       = (way_pri[3*w +: 3] <= id_pri[s1_part_id_ff]);
   end

   // victim filter
   always_comb begin
      offered   = s1_way_offered_ff & WAY_MASK;
      over      = max_enable_ff &&
                  (id_occ[s1_part_id_ff] >= CMP_W'(id_max[s1_part_id_ff]));
      max_keep  = offered & (own_ways |
                  (id_soft[s1_part_id_ff] ? s1_way_absent_ff : 16'h0000));
      after_max = offered;
      if (over) begin
         after_max = (max_keep != '0) ? max_keep : lowest_ways(offered, way_pri);
      end
      after_min = after_max;
      if (min_enable_ff) begin
         after_min = ((after_max & min_keep) != '0) ? (after_max & min_keep) :
                     lowest_ways(after_max, way_pri);
      end
   end

   // limit read
   always_comb begin
      kind_known = (s1_limit_kind_ff != mmpvf_pkg::KIND_UNKNOWN);
      case (s1_limit_kind_ff)
         mmpvf_pkg::KIND_MIN:  limit_read = id_min[s1_part_id_ff];
         mmpvf_pkg::KIND_MAX:  limit_read = id_max[s1_part_id_ff];
         mmpvf_pkg::KIND_SOFT: limit_read = 16'(id_soft[s1_part_id_ff]);
         default:              limit_read = mmpvf_pkg::LIMIT_NONE;
      endcase
   end

   // response and table update
   always_comb begin
      rsp_valid_in       = advance || (rsp_valid_ff && rsp_stall);
      rsp_victim_mask_in = rsp_victim_mask_ff;
      rsp_avail_mask_in  = rsp_avail_mask_ff;
      rsp_read_value_in  = rsp_read_value_ff;
      rsp_ok_in          = rsp_ok_ff;
      occupancy_in       = occupancy_ff;
      min_lines_in       = min_lines_ff;
      max_lines_in       = max_lines_ff;
      soft_flag_in       = soft_flag_ff;
      if (advance) begin
         rsp_victim_mask_in = '0;
         rsp_avail_mask_in  = '0;
         rsp_read_value_in  = '0;
         rsp_ok_in          = 1'b0;
         case (s1_mode_ff)
            mmpvf_pkg::MODE_VICTIM: begin
               rsp_victim_mask_in = after_min & WAY_MASK;
               rsp_avail_mask_in  = (over && !id_soft[s1_part_id_ff] &&
                                     (s1_avail_bitmap_ff != '0)) ?
                                    s1_avail_bitmap_ff : 16'hFFFF;
            end
            mmpvf_pkg::MODE_FILL: begin
               for (int i = 0; i < PARTITIONS; i++) begin
                  if (4'(i) == s1_part_id_ff && occupancy_ff[i] != '1) begin
                     occupancy_in[i] = occupancy_ff[i] + COUNT_WIDTH'(1);
                  end
               end
            end
            mmpvf_pkg::MODE_EVICT: begin
               for (int i = 0; i < PARTITIONS; i++) begin
                  if (4'(i) == s1_part_id_ff && occupancy_ff[i] != '0) begin
                     occupancy_in[i] = occupancy_ff[i] - COUNT_WIDTH'(1);
                  end
               end
            end
            mmpvf_pkg::MODE_WRITE: begin
               rsp_ok_in = kind_known;
               for (int i = 0; i < PARTITIONS; i++) begin
                  if (4'(i) == s1_part_id_ff) begin
                     case (s1_limit_kind_ff)
                        mmpvf_pkg::KIND_MIN:  min_lines_in[i] = s1_limit_value_ff;
                        mmpvf_pkg::KIND_MAX:  max_lines_in[i] = s1_limit_value_ff;
                        mmpvf_pkg::KIND_SOFT: soft_flag_in[i] = (s1_limit_value_ff != '0);
                        default: ;
                     endcase
                  end
               end
            end
            mmpvf_pkg::MODE_READ: begin
               rsp_ok_in         = kind_known;
               rsp_read_value_in = limit_read;
            end
            default: ;
         endcase
      end
   end

   // configuration writes
   always_comb begin
      max_enable_in = max_enable_ff;
      min_enable_in = min_enable_ff;
      if (csr_write_enable) begin
         case (csr_index)
            mmpvf_pkg::CSR_MAX_ENABLE: max_enable_in = csr_write_data;
            mmpvf_pkg::CSR_MIN_ENABLE: min_enable_in = csr_write_data;
            default: ;
         endcase
      end
   end

   assign s1_valid_in = load ? req_valid : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         max_enable_ff <= 1'b0;
         min_enable_ff <= 1'b0;
         for (int i = 0; i < PARTITIONS; i++) begin
            occupancy_ff[i] <= '0;
            min_lines_ff[i] <= '0;
            max_lines_ff[i] <= mmpvf_pkg::LIMIT_NONE;
            soft_flag_ff[i] <= 1'b0;
         end
      end else begin
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         max_enable_ff <= max_enable_in;
         min_enable_ff <= min_enable_in;
         occupancy_ff  <= occupancy_in;
         min_lines_ff  <= min_lines_in;
         max_lines_ff  <= max_lines_in;
         soft_flag_ff  <= soft_flag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s1_mode_ff           <= req_mode;
         s1_part_id_ff        <= req_part_id;
         s1_way_partitions_ff <= req_way_partitions;
         s1_way_offered_ff    <= req_way_offered;
         s1_way_absent_ff     <= req_way_absent;
         s1_avail_bitmap_ff   <= req_avail_bitmap;
         s1_limit_kind_ff     <= req_limit_kind;
         s1_limit_value_ff    <= req_limit_value;
      end
      rsp_victim_mask_ff <= rsp_victim_mask_in;
      rsp_avail_mask_ff  <= rsp_avail_mask_in;
      rsp_read_value_ff  <= rsp_read_value_in;
      rsp_ok_ff          <= rsp_ok_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_victim_mask = rsp_victim_mask_ff;
   assign rsp_avail_mask  = rsp_avail_mask_ff;
   assign rsp_read_value  = rsp_read_value_ff;
   assign rsp_ok          = rsp_ok_ff;

`ifndef SYNTHESIS
   a_stall_needs_request: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("input stalled with no request held");

   a_rsp_from_request: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff))
      else $error("response appeared without a request");

   a_victim_subset: assert property (@(posedge clock) disable iff (reset)
      (advance && s1_mode_ff == mmpvf_pkg::MODE_VICTIM) |=>
      ((rsp_victim_mask_ff & ~($past(s1_way_offered_ff) & WAY_MASK)) == '0))
      else $error("victim mask holds a way that was not offered");

   a_victim_nonempty: assert property (@(posedge clock) disable iff (reset)
      (advance && s1_mode_ff == mmpvf_pkg::MODE_VICTIM &&
       (s1_way_offered_ff & WAY_MASK) != '0) |=> (rsp_victim_mask_ff != '0))
      else $error("filter removed every offered way");

   a_masks_zero: assert property (@(posedge clock) disable iff (reset)
      (advance && s1_mode_ff != mmpvf_pkg::MODE_VICTIM) |=>
      (rsp_victim_mask_ff == '0 && rsp_avail_mask_ff == '0))
      else $error("masks set on a non-victim response");
`endif

endmodule
